/* rtl/baro_relative_altitude_top_defines.svh */
// ----------------------------------------------------------------------------
// Barometric relative altitude: assertion macros
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BARO_RELATIVE_ALTITUDE_TOP_DEFINES_SVH
`define BARO_RELATIVE_ALTITUDE_TOP_DEFINES_SVH

// same-cycle implication
`define BRA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bra_pkg.sv */
// ----------------------------------------------------------------------------
// Barometric relative altitude: package
// Item types, fixed-point constants and the log2/exp2 segment tables.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int PowTableBits = 8;
  localparam int Segs         = 1 << PowTableBits;
  localparam int LogRemBits   = 23 - PowTableBits;
  localparam int ExpRemBits   = 24 - PowTableBits;
  localparam int Latency      = 13;

  localparam logic [23:0] RefReset     = 24'd4150272;
  localparam logic [29:0] InvExpQ32    = 30'd816999676;
  localparam logic signed [16:0] KelvinOffset = 17'sd27315;
  localparam logic [14:0] AltNum       = 15'd26248;
  localparam logic [63:0] HalfDen      = 64'd325 << 23;
  localparam int          RecipShift   = 45;
  // ceil(2^45 / 325), exact floor division for dividends below 2^36
  localparam logic [36:0] AltRecip     = 37'd108259606428;

  typedef struct packed {
    logic [23:0]        pressure_raw;
    logic signed [15:0] temperature_raw;
  } item_in_t;

  typedef struct packed {
    logic signed [31:0] altitude_sixteenth_ft;
    logic               pressure_zero;
    logic               saturated;
  } item_out_t;

  typedef logic [24:0] log_tab_t [Segs+1];
  typedef logic [31:0] exp_tab_t [Segs+1];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic log_tab_t build_log();
    log_tab_t    tab;
    logic [63:0] x;
    logic [24:0] res;
    for (int i = 0; i < Segs; i++) begin
      x   = (64'd1 << 30) + (64'(i) << (30 - PowTableBits));
      res = '0;
      for (int k = 1; k <= 24; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          res[24-k] = 1'b1;
        end
      end
      tab[i] = res;
    end
    tab[Segs] = 25'd1 << 24;
    return tab;
  endfunction

  function automatic exp_tab_t build_exp();
    exp_tab_t    tab;
    logic [63:0] roots [1:PowTableBits];
    logic [63:0] acc;
    roots[1] = isqrt64(64'd2 << 60);
    for (int j = 2; j <= PowTableBits; j++) roots[j] = isqrt64(roots[j-1] << 30);
    for (int i = 0; i < Segs; i++) begin
      acc = 64'd1 << 30;
      for (int j = 1; j <= PowTableBits; j++) begin
        if (((i >> (PowTableBits - j)) & 1) != 0) acc = (acc * roots[j]) >> 30;
      end
      tab[i] = acc[31:0];
    end
    tab[Segs] = 32'h8000_0000;
    return tab;
  endfunction

  localparam log_tab_t LogTab = build_log();
  localparam exp_tab_t ExpTab = build_exp();

endpackage

/* rtl/bra_log2.sv */
// ----------------------------------------------------------------------------
// Barometric relative altitude: log2 unit
// Two-stage Q24 log2 of a 24-bit value: normalise and table read, then
// linear interpolation.
// ----------------------------------------------------------------------------
module bra_log2 (
  input  logic        clk_i,
  input  logic [23:0] x_i,
  output logic [28:0] y_o
);

  logic [4:0]                          msb;
  logic [23:0]                         norm;
  logic [bra_pkg::PowTableBits-1:0]    idx;
  logic [bra_pkg::PowTableBits:0]      idx_nx;
  logic [24:0]                         base_d;
  logic [24:0]                         diff_d;

  logic [4:0]                          msb_q;
  logic [24:0]                         base_q;
  logic [24:0]                         diff_q;
  logic [bra_pkg::LogRemBits-1:0]      rem_q;
  logic [bra_pkg::LogRemBits+24:0]     interp;
  logic [28:0]                         y_q;

  always_comb begin
    msb = '0;
    for (int k = 0; k < 24; k++) begin
      if (x_i[k]) msb = 5'(k);
    end
    norm   = x_i << (5'd23 - msb);
    idx    = norm[22:bra_pkg::LogRemBits];
    idx_nx = {1'b0, idx} + 1'b1;
    base_d = bra_pkg::LogTab[idx];
    diff_d = bra_pkg::LogTab[idx_nx] - base_d;
  end

  always_ff @(posedge clk_i) begin
    msb_q  <= msb;
    base_q <= base_d;
    diff_q <= diff_d;
    rem_q  <= norm[bra_pkg::LogRemBits-1:0];
  end

  assign interp = (diff_q * rem_q) >> bra_pkg::LogRemBits;

  always_ff @(posedge clk_i) begin
    y_q <= {msb_q, 24'd0} + 29'(base_q) + 29'(interp);
  end

  assign y_o = y_q;

endmodule

/* rtl/baro_relative_altitude_top.sv */
// ----------------------------------------------------------------------------
// Barometric relative altitude: top level
// Hypsometric altitude relative to a reference pressure, in 1/16 ft.
//
//   port group           dir  handshake                 item
//   start_i / in_i       in   start_i & !busy_o         bra_pkg::item_in_t
//   res_valid_o / res_o  out  strobe, one cycle         bra_pkg::item_out_t
//   cfg_*                in   cfg_valid_i & cfg_ready_o reference pressure
//
// One item per cycle; each result passes through the thirteen register
// stages (log2, scale, exp2, three products, divide).
// busy_o and cfg_ready_o stay low and high: there are no stalls.
// Reset clears the valid bits and loads the reference pressure.
// ----------------------------------------------------------------------------
`include "baro_relative_altitude_top_defines.svh"

module baro_relative_altitude_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  bra_pkg::item_in_t   in_i,
  output logic                res_valid_o,
  output bra_pkg::item_out_t  res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [23:0]         cfg_data_i
);

  localparam int Lat = bra_pkg::Latency;
  localparam int Erb = bra_pkg::ExpRemBits;
  localparam int Ptb = bra_pkg::PowTableBits;

  logic                accept;
  logic [Lat-1:0]      vld_q;
  logic [23:0]         ref_q;

  logic [23:0]         p0_q;
  logic [23:0]         r0_q;
  logic signed [15:0]  t_q  [8];
  logic [Lat-2:0]      pz_q;
  logic [6:0]          rz_q;

  logic [28:0]         lr;
  logic [28:0]         lp;
  logic signed [29:0]  l3;
  logic [28:0]         lm3_q;
  logic [4:3]          neg_q;
  logic [58:0]         prod4_q;

  logic [59:0]         ysum;
  logic [27:0]         ym;
  logic signed [28:0]  y5;
  logic [27:0]         yo;
  logic [Ptb-1:0]      eidx;
  logic [Ptb:0]        eidx_nx;
  logic [3:0]          hi5_q;
  logic [31:0]         ebase5_q;
  logic [31:0]         ediff5_q;
  logic [Erb-1:0]      erem5_q;

  logic [3:0]          hi6_q;
  logic [31:0]         v6_q;
  logic [Erb+31:0]     eint;

  logic [3:0]          sh;
  logic [32:0]         e7;
  logic signed [30:0]  d7_q;
  logic signed [16:0]  tk;
  logic signed [47:0]  dt8_q;
  logic signed [63:0]  prod9_q;
  logic [63:0]         mag;
  logic                neg10_q;
  logic [35:0]         m10_q;
  logic                neg11_q;
  logic [54:0]         plo11_q;
  logic [54:0]         phi11_q;

  logic [72:0]         qsum;
  logic [31:0]         q12;
  logic                sat12;
  bra_pkg::item_out_t  res_d;
  bra_pkg::item_out_t  res_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ref_q <= bra_pkg::RefReset;
    end else begin
      vld_q <= {vld_q[Lat-2:0], accept};
      if (cfg_valid_i && cfg_ready_o) ref_q <= cfg_data_i;
    end
  end

  // stage 0: input register
  always_ff @(posedge clk_i) begin
    p0_q    <= in_i.pressure_raw;
    r0_q    <= ref_q;
    t_q[0]  <= in_i.temperature_raw;
    pz_q[0] <= (in_i.pressure_raw == '0);
    rz_q[0] <= (ref_q == '0);
    for (int k = 1; k < 8; k++) t_q[k] <= t_q[k-1];
    for (int k = 1; k < Lat - 1; k++) pz_q[k] <= pz_q[k-1];
    for (int k = 1; k < 7; k++) rz_q[k] <= rz_q[k-1];
  end

  // stages 1-2: logarithms
  bra_log2 u_log_ref (.clk_i(clk_i), .x_i(r0_q), .y_o(lr));
  bra_log2 u_log_p   (.clk_i(clk_i), .x_i(p0_q), .y_o(lp));

  // stage 3: difference and magnitude
  assign l3 = $signed({1'b0, lr}) - $signed({1'b0, lp});

  // stage 5: scale by 1/5.257, table read for exp2
  always_comb begin
    ysum    = {1'b0, prod4_q} + (60'd1 << 31);
    ym      = ysum[59:32];
    y5      = neg_q[4] ? -$signed({1'b0, ym}) : $signed({1'b0, ym});
    yo      = 28'(y5 + 29'sd134217728);
    eidx    = yo[23:Erb];
    eidx_nx = {1'b0, eidx} + 1'b1;
  end

  assign eint = (ediff5_q * erem5_q) >> Erb;

  // stage 7: shift to Q24 with rounding
  always_comb begin
    sh = 4'd14 - hi6_q;
    e7 = ({1'b0, v6_q} + (33'd1 << (sh - 4'd1))) >> sh;
  end

  assign tk = 17'(t_q[7]) + bra_pkg::KelvinOffset;

  assign mag = prod9_q[63] ? 64'(-prod9_q) : 64'(prod9_q);

  always_ff @(posedge clk_i) begin
    lm3_q    <= l3[29] ? 29'(-l3) : 29'(l3);
    neg_q[3] <= l3[29];
    neg_q[4] <= neg_q[3];
    prod4_q  <= lm3_q * bra_pkg::InvExpQ32;
    hi5_q    <= yo[27:24];
    ebase5_q <= bra_pkg::ExpTab[eidx];
    ediff5_q <= bra_pkg::ExpTab[eidx_nx] - bra_pkg::ExpTab[eidx];
    erem5_q  <= yo[Erb-1:0];
    hi6_q    <= hi5_q;
    v6_q     <= ebase5_q + 32'(eint);
    d7_q     <= rz_q[6] ? -31'sd16777216 : $signed(31'(e7) - 31'd16777216);
    dt8_q    <= 48'(d7_q) * 48'(tk);
    prod9_q  <= 64'(dt8_q) * $signed({49'd0, bra_pkg::AltNum});
    neg10_q  <= prod9_q[63];
    m10_q    <= 36'((mag + bra_pkg::HalfDen) >> 24);
    neg11_q  <= neg10_q;
    plo11_q  <= m10_q[17:0] * bra_pkg::AltRecip;
    phi11_q  <= m10_q[35:18] * bra_pkg::AltRecip;
    res_q    <= res_d;
  end

  // stage 12: quotient, sign, clipping and zero-pressure override
  always_comb begin
    qsum  = {phi11_q, 18'd0} + 73'(plo11_q);
    q12   = 32'(qsum >> bra_pkg::RecipShift);
    sat12 = 1'b0;
    res_d = '0;
    if (neg11_q) begin
      if (q12 > 32'h8000_0000) begin
        q12   = 32'h8000_0000;
        sat12 = 1'b1;
      end
      res_d.altitude_sixteenth_ft = $signed(32'd0 - q12);
    end else begin
      if (q12 > 32'h7FFF_FFFF) begin
        q12   = 32'h7FFF_FFFF;
        sat12 = 1'b1;
      end
      res_d.altitude_sixteenth_ft = $signed(q12);
    end
    res_d.saturated = sat12;
    if (pz_q[Lat-2]) begin
      res_d.altitude_sixteenth_ft = '0;
      res_d.saturated             = 1'b0;
      res_d.pressure_zero         = 1'b1;
    end
  end

  assign res_valid_o = vld_q[Lat-1];
  assign res_o       = res_q;

  `BRA_ASSERT_IMPL(a_res_from_item, res_valid_o, $past(accept, Lat), "result without item")
  `BRA_ASSERT_IMPL(a_pz_zero, res_valid_o && res_o.pressure_zero, res_o.altitude_sixteenth_ft == 32'sd0 && !res_o.saturated, "zero pressure result not zero")
  `BRA_ASSERT_IMPL(a_sat_rail, res_valid_o && res_o.saturated, res_o.altitude_sixteenth_ft == 32'sh7FFF_FFFF || res_o.altitude_sixteenth_ft == 32'sh8000_0000, "saturated off rail")
  `BRA_ASSERT_NEXT(a_cfg_write, cfg_valid_i && cfg_ready_o, ref_q == $past(cfg_data_i), "reference not written")

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Relative altitude block: testbench
// Drives pressure/temperature items under several reference pressures and
// compares every result strobe with an in-bench fixed-point altitude model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int CycleLimit = 300000;

  class altitude_scoreboard;
    int unsigned         log_seg [257];
    int unsigned         exp_seg [257];
    logic [23:0]         ground_pressure;
    bra_pkg::item_out_t  pending_alt [$];
    int                  mismatches;

    function new();
      longint unsigned roots [1:8];
      longint unsigned x;
      longint unsigned acc;
      int unsigned     res;
      ground_pressure = bra_pkg::RefReset;
      mismatches      = 0;
      roots[1] = int_sqrt(64'd2 << 60);
      for (int j = 2; j <= 8; j++) roots[j] = int_sqrt(roots[j-1] << 30);
      for (int i = 0; i < 256; i++) begin
        x   = (64'd1 << 30) + (64'(i) << 22);
        res = 0;
        acc = 64'd1 << 30;
        for (int k = 1; k <= 24; k++) begin
          x = (x * x) >> 30;
          if (x >= (64'd1 << 31)) begin
            x = x >> 1;
            res = res | (32'd1 << (24 - k));
          end
        end
        log_seg[i] = res;
        for (int j = 1; j <= 8; j++)
          if (((i >> (8 - j)) & 1) != 0) acc = (acc * roots[j]) >> 30;
        exp_seg[i] = acc[31:0];
      end
      log_seg[256] = 32'd1 << 24;
      exp_seg[256] = 32'h8000_0000;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n_in);
      longint unsigned n;
      longint unsigned r;
      longint unsigned b;
      n = n_in;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint log2_fix(int unsigned x);
      int              msb;
      int unsigned     f;
      int unsigned     idx;
      int unsigned     rem;
      longint unsigned diff;
      msb = 23;
      while (msb > 0 && x[msb] == 1'b0) msb--;
      f    = ((x << (23 - msb)) & 32'hFF_FFFF) - (32'd1 << 23);
      idx  = f >> 15;
      rem  = f & 32'h7FFF;
      diff = 64'(log_seg[idx+1] - log_seg[idx]);
      return (longint'(msb) << 24) + longint'(log_seg[idx]) + longint'((diff * rem) >> 15);
    endfunction

    function longint exp2_fix(longint y);
      longint          yo;
      int              n;
      int              s;
      int unsigned     fr;
      int unsigned     idx;
      int unsigned     rem;
      longint unsigned diff;
      longint unsigned v;
      yo   = y + (longint'(8) << 24);
      n    = int'(yo >> 24) - 8;
      fr   = yo[23:0];
      idx  = fr >> 16;
      rem  = fr & 32'hFFFF;
      diff = 64'(exp_seg[idx+1] - exp_seg[idx]);
      v    = 64'(exp_seg[idx]) + ((diff * rem) >> 16);
      s    = 6 - n;
      return longint'((v + (64'd1 << (s - 1))) >> s);
    endfunction

    function bra_pkg::item_out_t altitude_of(bra_pkg::item_in_t it);
      bra_pkg::item_out_t r;
      longint          l;
      longint          ym;
      longint          e;
      longint          d;
      longint          tk;
      longint          prod;
      longint unsigned lm;
      longint unsigned mag;
      longint unsigned q;
      longint unsigned den;
      r = '0;
      if (it.pressure_raw == 24'd0) begin
        r.pressure_zero = 1'b1;
        return r;
      end
      if (ground_pressure == 24'd0) begin
        e = 0;
      end else begin
        l  = log2_fix(32'(ground_pressure)) - log2_fix(32'(it.pressure_raw));
        lm = (l < 0) ? -l : l;
        ym = longint'((lm * 64'd816999676 + (64'd1 << 31)) >> 32);
        e  = exp2_fix((l < 0) ? -ym : ym);
      end
      d    = e - (longint'(1) << 24);
      tk   = longint'(it.temperature_raw) + 27315;
      prod = d * tk * 26248;
      mag  = (prod < 0) ? -prod : prod;
      den  = 64'd325 << 24;
      q    = (mag + den / 2) / den;
      if (prod < 0) begin
        if (q > 64'h8000_0000) begin
          q = 64'h8000_0000;
          r.saturated = 1'b1;
        end
        r.altitude_sixteenth_ft = 32'(-q);
      end else begin
        if (q > 64'h7FFF_FFFF) begin
          q = 64'h7FFF_FFFF;
          r.saturated = 1'b1;
        end
        r.altitude_sixteenth_ft = q[31:0];
      end
      return r;
    endfunction

    function void note_item(bra_pkg::item_in_t it);
      pending_alt.push_back(altitude_of(it));
    endfunction

    function void check_result(bra_pkg::item_out_t got);
      bra_pkg::item_out_t exp_r;
      if (pending_alt.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending_alt.pop_front();
      if (got.altitude_sixteenth_ft !== exp_r.altitude_sixteenth_ft ||
          got.pressure_zero !== exp_r.pressure_zero ||
          got.saturated !== exp_r.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected alt %0d pz %b sat %b, got alt %0d pz %b sat %b",
                   exp_r.altitude_sixteenth_ft, exp_r.pressure_zero, exp_r.saturated,
                   got.altitude_sixteenth_ft, got.pressure_zero, got.saturated);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  bra_pkg::item_in_t  in_i = '0;
  logic               res_valid_o;
  bra_pkg::item_out_t res_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [23:0]        cfg_data_i = '0;

  altitude_scoreboard sb = new();
  int unsigned cycles = 0;
  bit          no_gaps;

  baro_relative_altitude_top i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .res_valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni && start_i && !busy_o) sb.note_item(in_i);
    if (rst_ni && res_valid_o) sb.check_result(res_o);
  end

  task automatic send_item(logic [23:0] p, logic [15:0] t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= '{pressure_raw: p, temperature_raw: t};
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
  endtask

  task automatic write_ground(logic [23:0] v);
    start_i <= 1'b0;
    while (sb.pending_alt.size() != 0) @(posedge clk_i);
    repeat (bra_pkg::Latency + 3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.ground_pressure = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    logic [23:0] p;
    int          span;
    int          off;
    span = int'(sb.ground_pressure >> 2) + 1;
    if ($urandom_range(0, 9) < 7 && sb.ground_pressure > 24'd16) begin
      off = $urandom_range(0, 2 * span) - span;
      p   = 24'(int'(sb.ground_pressure) + off);
    end else begin
      p = 24'($urandom());
    end
    if ($urandom_range(0, 49) == 0) p = 24'd0;
    send_item(p, 16'($urandom()));
  endtask

  initial begin
    logic [23:0] grounds [7];
    grounds = '{bra_pkg::RefReset, 24'd1, 24'hFF_FFFF, 24'd0, 24'd4150272 - 24'd600000,
                24'($urandom_range(3000000, 4300000)), 24'($urandom())};
    no_gaps = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (grounds[g]) begin
      write_ground(grounds[g]);
      // edge cases: zero, one and full-scale pressure, equal to ground,
      // temperature extremes and absolute zero or below
      send_item(24'd0, 16'sd2000);
      send_item(24'd1, 16'sd2000);
      send_item(24'hFF_FFFF, 16'sd2000);
      send_item(grounds[g], 16'sd2500);
      send_item(24'd1, 16'sh7FFF);
      send_item(24'hFF_FFFF, 16'sh8000);
      send_item(24'd1, 16'sh8000);
      send_item(24'd2000000, -16'sd27315);
      send_item(24'd3000000, -16'sd30000);
      send_item(24'hAAAAAA, 16'h5555);
      send_item(24'h555555, 16'hAAAA);
      for (int n = 0; n < 200; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        random_item();
      end
    end
    start_i <= 1'b0;
    while (sb.pending_alt.size() != 0) @(posedge clk_i);
    repeat (bra_pkg::Latency + 5) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_alt.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/bra_pkg.sv
rtl/bra_log2.sv
rtl/baro_relative_altitude_top.sv
tb/tb_top.sv
